### src/siq_pkg.sv
// Shared types and constants for the sorted insert queue.
`default_nettype none
package siq_pkg;

  localparam int SIQ_DEPTH        = 16;
  localparam int SIQ_PAYLOAD_BITS = 32;
  localparam int PAYLOAD_MAX_BITS = 48;
  localparam int KEY_W            = 16;
  localparam int IN_PAYLOAD_W     = 32;
  localparam int OUT_COUNT_W      = 5;
  localparam int CQ_DEPTH         = 2;
  localparam int CQ_PTR_W         = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W         = $clog2(CQ_DEPTH + 1);

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_SORTED = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SORTED = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [KEY_W-1:0]        key;
    logic [IN_PAYLOAD_W-1:0] payload;
  } cmd_t;

endpackage
`default_nettype wire

### src/siq_front.sv
// Front end: accepts commands and decodes the operation kind.
`default_nettype none
module siq_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_kind,
  input  wire logic [siq_pkg::KEY_W-1:0]        in_key,
  input  wire logic [siq_pkg::IN_PAYLOAD_W-1:0] in_payload,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output siq_pkg::cmd_t                         q_cmd
);
  import siq_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r;
  op_t  op_dec;
  logic accept;

  always_comb begin
    case (in_kind)
      KIND_APPEND: op_dec = OP_APPEND;
      KIND_SORTED: op_dec = OP_SORTED;
      KIND_REMOVE: op_dec = OP_REMOVE;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign busy    = vld_r && q_full;
  assign accept  = start && !busy;
  assign q_push  = vld_r && !q_full;
  assign q_cmd   = cmd_r;
  assign vld_nxt = accept || (vld_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op      <= op_dec;
      cmd_r.key     <= in_key;
      cmd_r.payload <= in_payload;
    end
  end

endmodule
`default_nettype wire

### src/siq_cmd_fifo.sv
// Short command queue between the front end and the execution back end.
`default_nettype none
module siq_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire siq_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output siq_pkg::cmd_t      pop_cmd
);
  import siq_pkg::*;

  cmd_t                mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= CQ_PTR_W'((32'(wr_ptr_r) + 1) % CQ_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_r <= CQ_PTR_W'((32'(rd_ptr_r) + 1) % CQ_DEPTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### src/siq_back.sv
// Back end: shift-register entry cells and the registered result.
`default_nettype none
module siq_back #(
  parameter int DEPTH        = siq_pkg::SIQ_DEPTH,
  parameter int PAYLOAD_BITS = siq_pkg::SIQ_PAYLOAD_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  input  wire siq_pkg::cmd_t                    q_cmd,
  output logic                                  q_pop,
  output logic                                  out_strobe,
  output logic                                  out_item_valid,
  output logic [siq_pkg::KEY_W-1:0]             out_item_key,
  output logic [siq_pkg::IN_PAYLOAD_W-1:0]      out_item_payload,
  output logic [siq_pkg::OUT_COUNT_W-1:0]       out_count,
  output logic                                  out_is_empty,
  output logic                                  out_is_full,
  output logic [1:0]                            out_status
);
  import siq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0]        key_r   [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_r   [DEPTH];
  logic [KEY_W-1:0]        key_nxt [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_nxt [DEPTH];
  logic [KEY_W-1:0]        below_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] below_pay [DEPTH];
  logic [KEY_W-1:0]        above_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] above_pay [DEPTH];
  logic [DEPTH-1:0]        ins, ins_prev, wen;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    exec, is_ins, full, do_ins, do_rem, run, live, gt;
  logic [PAYLOAD_MAX_BITS-1:0] in_wide, head_wide;
  logic [PAYLOAD_BITS-1:0]     new_pay;
  logic [CW+OUT_COUNT_W-1:0]   cnt_wide;
  status_t                     status_nxt;

  logic                    strobe_r, item_valid_r, is_empty_r, is_full_r;
  logic [KEY_W-1:0]        item_key_r;
  logic [IN_PAYLOAD_W-1:0] item_payload_r;
  logic [OUT_COUNT_W-1:0]  count_r;
  status_t                 status_r;

  assign exec    = !q_empty;
  assign q_pop   = exec;
  assign is_ins  = (q_cmd.op == OP_APPEND) || (q_cmd.op == OP_SORTED);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_ins  = exec && is_ins && !full;
  assign do_rem  = exec && (q_cmd.op == OP_REMOVE) && (cnt_r != '0);
  assign in_wide = PAYLOAD_MAX_BITS'(q_cmd.payload);
  assign new_pay = in_wide[PAYLOAD_BITS-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
    if (i > 0) begin : g_lo
      assign below_key[i] = key_r[i-1];
      assign below_pay[i] = pay_r[i-1];
    end else begin : g_lo0
      assign below_key[i] = key_r[i];
      assign below_pay[i] = pay_r[i];
    end
    if (i < DEPTH - 1) begin : g_hi
      assign above_key[i] = key_r[i+1];
      assign above_pay[i] = pay_r[i+1];
    end else begin : g_hi0
      assign above_key[i] = key_r[i];
      assign above_pay[i] = pay_r[i];
    end
  end

  // Insert point is the first live key above a sorted new key, else the tail.
  always_comb begin
    run = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      live   = (CW'(i) < cnt_r);
      gt     = live && (q_cmd.op == OP_SORTED) && (key_r[i] > q_cmd.key);
      run    = run || gt;
      ins[i] = (live && run) || (CW'(i) == cnt_r);
    end
  end

  assign ins_prev = {ins[DEPTH-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      wen[i] = do_rem || (do_ins && ins[i]);
      if (do_rem) begin
        key_nxt[i] = above_key[i];
        pay_nxt[i] = above_pay[i];
      end else if (ins_prev[i]) begin
        key_nxt[i] = below_key[i];
        pay_nxt[i] = below_pay[i];
      end else begin
        key_nxt[i] = q_cmd.key;
        pay_nxt[i] = new_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (wen[i]) begin
        key_r[i] <= key_nxt[i];
        pay_r[i] <= pay_nxt[i];
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    if (do_ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (exec && is_ins) begin
      status_nxt = ST_FULL;
    end else if (exec && (q_cmd.op == OP_REMOVE)) begin
      status_nxt = ST_EMPTY;
    end
  end

  assign head_wide = PAYLOAD_MAX_BITS'(pay_r[0]);
  assign cnt_wide  = (CW + OUT_COUNT_W)'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      item_valid_r   <= do_rem;
      item_key_r     <= do_rem ? key_r[0] : '0;
      item_payload_r <= do_rem ? head_wide[IN_PAYLOAD_W-1:0] : '0;
      count_r        <= cnt_wide[OUT_COUNT_W-1:0];
      is_empty_r     <= (cnt_nxt == '0);
      is_full_r      <= (cnt_nxt == CW'(DEPTH));
      status_r       <= status_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_item_valid   = item_valid_r;
  assign out_item_key     = item_key_r;
  assign out_item_payload = item_payload_r;
  assign out_count        = count_r;
  assign out_is_empty     = is_empty_r;
  assign out_is_full      = is_full_r;
  assign out_status       = status_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above capacity");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_ins && full) |=> (cnt_r == $past(cnt_r)))
    else $error("refused insert changed the count");
  a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("remove did not decrement the count");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_strobe)
    else $error("executed command produced no result");
`endif

endmodule
`default_nettype wire

### src/sorted_insert_queue_core.sv
// Top level of the sorted insert queue.
//
// A queue of up to DEPTH key/payload entries held compacted from the head.
// Commands enter on start/busy: a transfer happens at a rising edge with
// start high and busy low, carrying in_kind, in_key and in_payload.
// Kind 0 appends at the tail, kind 1 inserts after every held entry whose
// key is less than or equal to in_key, kind 2 removes the head, kind 3 is
// ignored. Each command yields exactly one result, shown for one cycle with
// out_strobe high: removed entry, count, empty/full flags and status.
// The command passes the front register and the command queue; the back end
// then executes it from the command queue and registers the result.
// Throughput: one command per cycle while busy is low; the back end finishes
// one queue operation each cycle, its per-cell key compares in parallel.
// busy rises only if the command queue fills, which the back end never
// lets persist. The receiver cannot stall; results are never held.
// Reset (rst_n low, synchronous) empties the queue and drops queued
// commands; entry contents are not cleared and need no clearing pass.
`default_nettype none
module sorted_insert_queue_core #(
  parameter int DEPTH        = siq_pkg::SIQ_DEPTH,
  parameter int PAYLOAD_BITS = siq_pkg::SIQ_PAYLOAD_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_kind,
  input  wire logic [siq_pkg::KEY_W-1:0]        in_key,
  input  wire logic [siq_pkg::IN_PAYLOAD_W-1:0] in_payload,
  output logic                                  out_strobe,
  output logic                                  out_item_valid,
  output logic [siq_pkg::KEY_W-1:0]             out_item_key,
  output logic [siq_pkg::IN_PAYLOAD_W-1:0]      out_item_payload,
  output logic [siq_pkg::OUT_COUNT_W-1:0]       out_count,
  output logic                                  out_is_empty,
  output logic                                  out_is_full,
  output logic [1:0]                            out_status
);
  import siq_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  siq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_key     (in_key),
    .in_payload (in_payload),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  siq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  siq_back #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_strobe       (out_strobe),
    .out_item_valid   (out_item_valid),
    .out_item_key     (out_item_key),
    .out_item_payload (out_item_payload),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

### bench/sorted_queue_monitor.sv
// Monitor that predicts sorted insert queue results and compares them on the result port.
`timescale 1ns / 100ps
module sorted_queue_monitor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             busy,
  input  wire logic [1:0]                       in_kind,
  input  wire logic [siq_pkg::KEY_W-1:0]        in_key,
  input  wire logic [siq_pkg::IN_PAYLOAD_W-1:0] in_payload,
  input  wire logic                             out_strobe,
  input  wire logic                             out_item_valid,
  input  wire logic [siq_pkg::KEY_W-1:0]        out_item_key,
  input  wire logic [siq_pkg::IN_PAYLOAD_W-1:0] out_item_payload,
  input  wire logic [siq_pkg::OUT_COUNT_W-1:0]  out_count,
  input  wire logic                             out_is_empty,
  input  wire logic                             out_is_full,
  input  wire logic [1:0]                       out_status,
  output int                                    mismatches,
  output int                                    outstanding
);
  import siq_pkg::*;

  typedef struct {
    logic                    item_valid;
    logic [KEY_W-1:0]        item_key;
    logic [IN_PAYLOAD_W-1:0] item_payload;
    logic [OUT_COUNT_W-1:0]  count;
    logic                    is_empty;
    logic                    is_full;
    status_t                 status;
  } queue_result_t;

  logic [KEY_W-1:0]        held_key     [SIQ_DEPTH];
  logic [IN_PAYLOAD_W-1:0] held_payload [SIQ_DEPTH];
  int                      held_count;
  queue_result_t           pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    held_count  = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  task automatic apply_queue_op(input op_t op, input logic [KEY_W-1:0] key,
                                input logic [IN_PAYLOAD_W-1:0] payload,
                                output queue_result_t res);
    int pos;
    res.item_valid   = 1'b0;
    res.item_key     = '0;
    res.item_payload = '0;
    res.status       = ST_OK;
    case (op)
      OP_APPEND, OP_SORTED: begin
        if (held_count >= SIQ_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = held_count;
          if (op == OP_SORTED) begin
            pos = 0;
            while (pos < held_count && held_key[pos] <= key) pos++;
          end
          for (int j = held_count; j > pos; j--) begin
            held_key[j]     = held_key[j-1];
            held_payload[j] = held_payload[j-1];
          end
          held_key[pos]     = key;
          held_payload[pos] = payload;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_valid   = 1'b1;
          res.item_key     = held_key[0];
          res.item_payload = held_payload[0];
          for (int j = 0; j + 1 < held_count; j++) begin
            held_key[j]     = held_key[j+1];
            held_payload[j] = held_payload[j+1];
          end
          held_count--;
        end
      end
      default: ;
    endcase
    res.count    = held_count[OUT_COUNT_W-1:0];
    res.is_empty = (held_count == 0);
    res.is_full  = (held_count == SIQ_DEPTH);
  endtask

  always @(posedge clk) begin
    queue_result_t exp_res;
    queue_result_t new_res;
    if (!rst_n) begin
      held_count = 0;
      pending_results.delete();
    end else begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result", 32'(out_count), 32'd0);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_item_valid !== exp_res.item_valid)
            flag_mismatch("item_valid", 32'(out_item_valid), 32'(exp_res.item_valid));
          if (out_item_key !== exp_res.item_key)
            flag_mismatch("item_key", 32'(out_item_key), 32'(exp_res.item_key));
          if (out_item_payload !== exp_res.item_payload)
            flag_mismatch("item_payload", out_item_payload, exp_res.item_payload);
          if (out_count !== exp_res.count)
            flag_mismatch("count", 32'(out_count), 32'(exp_res.count));
          if (out_is_empty !== exp_res.is_empty)
            flag_mismatch("is_empty", 32'(out_is_empty), 32'(exp_res.is_empty));
          if (out_is_full !== exp_res.is_full)
            flag_mismatch("is_full", 32'(out_is_full), 32'(exp_res.is_full));
          if (out_status !== exp_res.status)
            flag_mismatch("status", 32'(out_status), 32'(exp_res.status));
        end
      end
      if (start && !busy) begin
        apply_queue_op(op_t'(in_kind), in_key, in_payload, new_res);
        pending_results.push_back(new_res);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### bench/testbench.sv
// Top of the sorted insert queue bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import siq_pkg::*;

  localparam int RANDOM_OPS  = 450;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_kind = OP_NOP;
  logic [KEY_W-1:0]        in_key = '0;
  logic [IN_PAYLOAD_W-1:0] in_payload = '0;
  logic                    out_strobe;
  logic                    out_item_valid;
  logic [KEY_W-1:0]        out_item_key;
  logic [IN_PAYLOAD_W-1:0] out_item_payload;
  logic [OUT_COUNT_W-1:0]  out_count;
  logic                    out_is_empty;
  logic                    out_is_full;
  logic [1:0]              out_status;
  int                      mismatches;
  int                      outstanding;
  int                      cycles = 0;
  logic                    idle_enabled = 1'b1;

  always #5 clk = ~clk;

  sorted_insert_queue_core DUT (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_payload,
    .out_strobe, .out_item_valid, .out_item_key, .out_item_payload,
    .out_count, .out_is_empty, .out_is_full, .out_status
  );

  sorted_queue_monitor monitor (
    .clk, .rst_n, .start, .busy, .in_kind, .in_key, .in_payload,
    .out_strobe, .out_item_valid, .out_item_key, .out_item_payload,
    .out_count, .out_is_empty, .out_is_full, .out_status,
    .mismatches, .outstanding
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic issue_command(input op_t op, input logic [KEY_W-1:0] key,
                               input logic [IN_PAYLOAD_W-1:0] payload);
    int gap;
    gap = idle_enabled ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_kind    <= op;
    in_key     <= key;
    in_payload <= payload;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(0, 7));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  initial begin
    int   real_ops;
    int   fill_pct;
    int   pick;
    op_t  op;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(OP_REMOVE, 16'h1234, 32'hDEADBEEF);
    issue_command(OP_NOP, 16'hFFFF, 32'hFFFFFFFF);
    for (int i = 0; i < SIQ_DEPTH; i++) begin
      if (i == 0)
        issue_command(OP_APPEND, 16'h0000, 32'h00000000);
      else if (i == 1)
        issue_command(OP_SORTED, 16'hFFFF, 32'hFFFFFFFF);
      else
        issue_command((i % 2) ? OP_SORTED : OP_APPEND,
                      (i % 3 == 0) ? 16'h8000 :
                      ((i % 3 == 1) ? KEY_W'(16'hFFFF - i) : KEY_W'(i)),
                      $urandom);
    end
    issue_command(OP_APPEND, 16'h0001, $urandom);
    issue_command(OP_SORTED, 16'h0000, $urandom);
    issue_command(OP_NOP, 16'h0000, 32'h0);
    issue_command(OP_REMOVE, 16'hFFFF, 32'hFFFFFFFF);
    issue_command(OP_REMOVE, 16'h0000, 32'h0);

    real_ops = 0;
    fill_pct = 80;
    while (real_ops < RANDOM_OPS) begin
      if ($urandom_range(0, 19) == 0) fill_pct = 100 - fill_pct;
      if ($urandom_range(0, 29) == 0) idle_enabled = ~idle_enabled;
      pick = $urandom_range(0, 99);
      if (pick < 4)
        op = OP_NOP;
      else if ($urandom_range(1, 100) <= fill_pct)
        op = $urandom_range(0, 1) ? OP_SORTED : OP_APPEND;
      else
        op = OP_REMOVE;
      if (op != OP_NOP) real_ops++;
      issue_command(op, draw_key(), $urandom);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
